[src/bcdc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click detector package
// Shared widths, reset values, register indexes and event codes.
// ----------------------------------------------------------------------------
package bcdc_pkg;

    // Default width of the debounce and window counters.
    localparam int COUNT_WIDTH_DEF = 16;

    // Width of the tick length registers.
    localparam int TICK_W = 16;

    // Configuration port widths.
    localparam int CFG_IDX_W = 2;

    // Width of the click event code.
    localparam int EVENT_W = 2;

    // Register reset values in ticks.
    localparam logic [TICK_W-1:0] DEBOUNCE_TICKS_RST = 16'd12;
    localparam logic [TICK_W-1:0] DOUBLE_TICKS_RST   = 16'd200;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_TICKS   = 2'd1;

    // Click event codes.
    localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
    localparam logic [EVENT_W-1:0] EV_SINGLE = 2'd1;
    localparam logic [EVENT_W-1:0] EV_DOUBLE = 2'd2;

endpackage

[src/bcdc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click detector channel interfaces
// Input sample, click event and configuration write channels.
// ----------------------------------------------------------------------------

// Button sample channel.
interface bcdc_in_if;
    logic valid;
    logic ready;
    logic button_level;

    modport source (output valid, output button_level, input ready);
    modport sink   (input valid, input button_level, output ready);
endinterface

// Click event channel.
interface bcdc_out_if;
    logic                        valid;
    logic                        ready;
    logic [bcdc_pkg::EVENT_W-1:0] click_event;

    modport source (output valid, output click_event, input ready);
    modport sink   (input valid, input click_event, output ready);
endinterface

// Configuration write channel.
interface bcdc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bcdc_pkg::CFG_IDX_W-1:0] index;
    logic [bcdc_pkg::TICK_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/button_click_double_click_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click and double-click detector
// Debounces an active-low button sampled once per tick and reports single
// and double clicks, one event code per sample.
// ----------------------------------------------------------------------------
// Each accepted sample produces exactly one event code (none, single or
// double click) in the output register in the next cycle. A new sample can be
// accepted every cycle; the only thing that holds the input back is a result
// still waiting in the output register while the sink is not ready, so the
// sustained rate is one sample per cycle. Debounce and window lengths are set
// in ticks through the configuration channel (index 0 debounce length, index
// 1 double-click window) and should be written only while no sample is in
// flight. The counters saturate at 2**COUNT_WIDTH-1 and a length above that
// is treated as that value.
// ----------------------------------------------------------------------------
module button_click_double_click_detector #(
    parameter int COUNT_WIDTH = bcdc_pkg::COUNT_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bcdc_in_if.sink    i_in,
    bcdc_out_if.source o_out,
    bcdc_cfg_if.sink   i_cfg
);
    import bcdc_pkg::*;

    // Width used for counter against length compares.
    localparam int CMP_W = (COUNT_WIDTH > TICK_W) ? COUNT_WIDTH : TICK_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    // Configuration registers.
    logic [TICK_W-1:0] r_deb_ticks;
    logic [TICK_W-1:0] r_dbl_ticks;

    // Detector state.
    logic                   r_prev_level, n_prev_level;
    logic                   r_debouncing, n_debouncing;
    logic [COUNT_WIDTH-1:0] r_deb_cnt,    n_deb_cnt;
    logic                   r_trig_level, n_trig_level;
    logic                   r_win_open,   n_win_open;
    logic [COUNT_WIDTH-1:0] r_win_cnt,    n_win_cnt;

    // Output register.
    logic               r_out_valid;
    logic [EVENT_W-1:0] r_out_event, n_event;

    logic                   w_accept;
    logic [COUNT_WIDTH-1:0] w_win_adv;
    logic [COUNT_WIDTH-1:0] w_deb_adv;
    logic [CMP_W-1:0]       w_deb_lim;
    logic [CMP_W-1:0]       w_dbl_lim;

    // The input stalls only while a result waits for a busy sink.
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign w_accept    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid       = r_out_valid;
    assign o_out.click_event = r_out_event;

    // Lengths clamped to the counter range.
    assign w_deb_lim = (CMP_W'(r_deb_ticks) > CMP_W'(CNT_MAX)) ? CMP_W'(CNT_MAX)
                                                              : CMP_W'(r_deb_ticks);
    assign w_dbl_lim = (CMP_W'(r_dbl_ticks) > CMP_W'(CNT_MAX)) ? CMP_W'(CNT_MAX)
                                                              : CMP_W'(r_dbl_ticks);

    // Saturating counter increments.
    assign w_win_adv = (r_win_cnt == CNT_MAX) ? r_win_cnt : r_win_cnt + COUNT_WIDTH'(1);
    assign w_deb_adv = (r_deb_cnt == CNT_MAX) ? r_deb_cnt : r_deb_cnt + COUNT_WIDTH'(1);

    // One tick of the detector: window first, then debounce.
    always_comb begin
        n_prev_level = r_prev_level;
        n_debouncing = r_debouncing;
        n_deb_cnt    = r_deb_cnt;
        n_trig_level = r_trig_level;
        n_win_open   = r_win_open;
        n_win_cnt    = r_win_cnt;
        n_event      = EV_NONE;

        if (w_accept) begin
            if (r_win_open) begin
                n_win_cnt = w_win_adv;
                if (CMP_W'(w_win_adv) >= w_dbl_lim) begin
                    n_win_open = 1'b0;
                end
            end

            if (r_debouncing) begin
                n_deb_cnt = w_deb_adv;
                if (CMP_W'(w_deb_adv) >= w_deb_lim) begin
                    n_debouncing = 1'b0;
                    // A confirmed press is a click; a second one in the window is a double.
                    if ((i_in.button_level == r_trig_level) && !i_in.button_level) begin
                        if (n_win_open) begin
                            n_event = EV_DOUBLE;
                        end else begin
                            n_win_open = 1'b1;
                            n_win_cnt  = '0;
                            n_event    = EV_SINGLE;
                        end
                    end
                end
            end else begin
                if (i_in.button_level != r_prev_level) begin
                    n_trig_level = i_in.button_level;
                    n_debouncing = 1'b1;
                    n_deb_cnt    = '0;
                end
                n_prev_level = i_in.button_level;
            end
        end
    end

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb_ticks <= DEBOUNCE_TICKS_RST;
            r_dbl_ticks <= DOUBLE_TICKS_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_DEBOUNCE_TICKS: r_deb_ticks <= i_cfg.data;
                CFG_DOUBLE_TICKS:   r_dbl_ticks <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Detector state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= 1'b1;
            r_debouncing <= 1'b0;
            r_deb_cnt    <= '0;
            r_trig_level <= 1'b1;
            r_win_open   <= 1'b0;
            r_win_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_prev_level <= n_prev_level;
            r_debouncing <= n_debouncing;
            r_deb_cnt    <= n_deb_cnt;
            r_trig_level <= n_trig_level;
            r_win_open   <= n_win_open;
            r_win_cnt    <= n_win_cnt;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Event payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_event <= n_event;
        end
    end

endmodule

[src/bcdc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click detector port checker
// Watches the top-level ports for handshake and event coding errors.
// ----------------------------------------------------------------------------
module bcdc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [bcdc_pkg::EVENT_W-1:0] i_out_event
);
    import bcdc_pkg::*;

    // Every accepted sample yields a result on the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("accepted sample produced no result");

    // With no result pending, the input is never held off.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output register");

    // Only defined event codes are delivered.
    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_event == EV_NONE || i_out_event == EV_SINGLE ||
                         i_out_event == EV_DOUBLE))
        else $error("undefined click event code");

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_event)))
        else $error("stalled result changed");

endmodule

bind button_click_double_click_detector bcdc_checker u_bcdc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_event (o_out.click_event)
);
